// ===== rtl/core/lbc_pkg.sv =====
`timescale 1ns / 1ps

package lbc_pkg;

    localparam int OP_W        = 2;
    localparam int BLOCK_NUM_W = 32;
    localparam int INDEX_W     = 4;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNHELD   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic search;
        logic decide;
        logic commit;
    } lbc_cmd_t;

    typedef struct packed {
        logic rsp_busy;
    } lbc_sts_t;

endpackage

// ===== rtl/core/lbc_req_if.sv =====
`timescale 1ns / 1ps

interface lbc_req_if
    import lbc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [BLOCK_NUM_W-1:0] block_number;
    logic [INDEX_W-1:0]     entry_index;

    modport source (
        output valid,
        input  ready,
        output operation,
        output block_number,
        output entry_index
    );

    modport sink (
        input  valid,
        output ready,
        input  operation,
        input  block_number,
        input  entry_index
    );
endinterface

// ===== rtl/core/lbc_rsp_if.sv =====
`timescale 1ns / 1ps

interface lbc_rsp_if
    import lbc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [INDEX_W-1:0]     granted_entry;
    logic                   hit;
    logic                   load_request;
    logic                   writeback_request;
    logic [BLOCK_NUM_W-1:0] writeback_block;

    modport source (
        output valid,
        input  ready,
        output status,
        output granted_entry,
        output hit,
        output load_request,
        output writeback_request,
        output writeback_block
    );

    modport sink (
        input  valid,
        output ready,
        input  status,
        input  granted_entry,
        input  hit,
        input  load_request,
        input  writeback_request,
        input  writeback_block
    );
endinterface

// ===== rtl/core/lbc_ctrl.sv =====
`timescale 1ns / 1ps

module lbc_ctrl
    import lbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lbc_sts_t sts,
    output lbc_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the previous word has left the output register
                if (!sts.rsp_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lbc_datapath.sv =====
`timescale 1ns / 1ps

module lbc_datapath
    import lbc_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int BLOCK_BITS = 32,
    parameter int COUNT_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lbc_cmd_t               cmd,
    output lbc_sts_t               sts,
    input  logic [OP_W-1:0]        operation,
    input  logic [BLOCK_NUM_W-1:0] block_number,
    input  logic [INDEX_W-1:0]     entry_index,
    lbc_rsp_if.source              rsp
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int WIDE_W = (BLOCK_BITS > BLOCK_NUM_W) ? BLOCK_BITS : BLOCK_NUM_W;
    localparam int GNT_W  = (RANK_W > INDEX_W) ? RANK_W : INDEX_W;
    localparam logic [RANK_W-1:0]     RANK_MAX  = RANK_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // entry state
    logic [BLOCK_BITS-1:0] tag_reg   [ENTRIES];
    logic [BLOCK_BITS-1:0] tag_next  [ENTRIES];
    logic [COUNT_BITS-1:0] count_reg [ENTRIES];
    logic [COUNT_BITS-1:0] count_next[ENTRIES];
    logic [RANK_W-1:0]     rank_reg  [ENTRIES];
    logic [RANK_W-1:0]     rank_next [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [ENTRIES-1:0]    dirty_reg;
    logic [ENTRIES-1:0]    dirty_next;

    // request
    logic [OP_W-1:0]       op_reg;
    logic [BLOCK_BITS-1:0] blk_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [WIDE_W-1:0]     blk_wide;

    // search and decide
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] match_next;
    logic [ENTRIES-1:0] free_reg;
    logic [ENTRIES-1:0] free_next;
    logic [ENTRIES-1:0] idxv_reg;
    logic [ENTRIES-1:0] idxv_next;
    logic [ENTRIES-1:0] sel_reg;
    logic [ENTRIES-1:0] sel_next;
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic               hit_reg;
    logic               found_reg;

    // selected entry
    logic [COUNT_BITS-1:0] sel_count;
    logic [BLOCK_BITS-1:0] sel_tag;
    logic [RANK_W-1:0]     sel_rank;
    logic [RANK_W-1:0]     sel_idx;
    logic                  sel_valid;
    logic                  sel_dirty;
    logic [GNT_W-1:0]      sel_idx_wide;
    logic [WIDE_W-1:0]     sel_tag_wide;

    // commit decision
    logic [STATUS_W-1:0]   status_dec;
    logic [COUNT_BITS-1:0] new_count;
    logic                  write_count;
    logic                  do_fill;
    logic                  set_dirty;
    logic                  do_promote;
    logic                  grant_dec;
    logic                  hit_dec;
    logic                  load_dec;
    logic                  wb_dec;

    // output word
    logic                   rsp_valid_reg;
    logic [STATUS_W-1:0]    rsp_status_reg;
    logic [INDEX_W-1:0]     rsp_entry_reg;
    logic                   rsp_hit_reg;
    logic                   rsp_load_reg;
    logic                   rsp_wb_reg;
    logic [BLOCK_NUM_W-1:0] rsp_wb_block_reg;

    assign blk_wide = WIDE_W'(block_number);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            blk_reg <= blk_wide[BLOCK_BITS-1:0];
            idx_reg <= entry_index;
        end
        if (cmd.search)
        begin
            match_reg <= match_next;
            free_reg  <= free_next;
            idxv_reg  <= idxv_next;
        end
        if (cmd.decide)
        begin
            sel_reg   <= sel_next;
            hit_reg   <= |match_reg;
            found_reg <= |free_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = valid_reg[i] && (tag_reg[i] == blk_reg);
            free_next[i]  = (count_reg[i] == '0);
            idxv_next[i]  = (32'(idx_reg) == 32'(i));
        end
    end

    // lowest matching entry; least recent free entry by pairwise rank compare
    assign hit_vec = match_reg & (~match_reg + ENTRIES'(1));

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            victim_vec[i] = free_reg[i];
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (free_reg[j] && (rank_reg[j] < rank_reg[i]))
                begin
                    victim_vec[i] = 1'b0;
                end
            end
        end
        if (op_reg == OP_ACQUIRE)
        begin
            sel_next = (|match_reg) ? hit_vec : victim_vec;
        end
        else
        begin
            sel_next = idxv_reg;
        end
    end

    always_comb
    begin
        sel_count = '0;
        sel_tag   = '0;
        sel_rank  = '0;
        sel_idx   = '0;
        sel_valid = 1'b0;
        sel_dirty = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sel_reg[i])
            begin
                sel_count = sel_count | count_reg[i];
                sel_tag   = sel_tag | tag_reg[i];
                sel_rank  = sel_rank | rank_reg[i];
                sel_idx   = sel_idx | RANK_W'(i);
                sel_valid = sel_valid | valid_reg[i];
                sel_dirty = sel_dirty | dirty_reg[i];
            end
        end
    end

    assign sel_idx_wide = GNT_W'(sel_idx);
    assign sel_tag_wide = WIDE_W'(sel_tag);

    always_comb
    begin
        status_dec  = STAT_OK;
        new_count   = sel_count;
        write_count = 1'b0;
        do_fill     = 1'b0;
        set_dirty   = 1'b0;
        do_promote  = 1'b0;
        grant_dec   = 1'b0;
        hit_dec     = 1'b0;
        load_dec    = 1'b0;
        wb_dec      = 1'b0;
        case (op_reg)
            OP_ACQUIRE:
            begin
                if (hit_reg)
                begin
                    if (sel_count == COUNT_MAX)
                    begin
                        status_dec = STAT_OVERFLOW;
                    end
                    else
                    begin
                        new_count   = sel_count + COUNT_ONE;
                        write_count = 1'b1;
                        do_promote  = 1'b1;
                        grant_dec   = 1'b1;
                        hit_dec     = 1'b1;
                    end
                end
                else if (!found_reg)
                begin
                    status_dec = STAT_NO_FREE;
                end
                else
                begin
                    new_count   = COUNT_ONE;
                    write_count = 1'b1;
                    do_fill     = 1'b1;
                    do_promote  = 1'b1;
                    grant_dec   = 1'b1;
                    load_dec    = 1'b1;
                    wb_dec      = sel_valid && sel_dirty;
                end
            end
            OP_MARK:
            begin
                set_dirty = sel_valid;
            end
            OP_RELEASE:
            begin
                if (sel_count == '0)
                begin
                    status_dec = STAT_UNHELD;
                end
                else
                begin
                    new_count   = sel_count - COUNT_ONE;
                    write_count = 1'b1;
                    do_promote  = (sel_count == COUNT_ONE);
                end
            end
            default:
            begin
                status_dec = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tag_next[i]   = tag_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];
            if (cmd.commit)
            begin
                if (sel_reg[i])
                begin
                    if (write_count)
                    begin
                        count_next[i] = new_count;
                    end
                    if (do_fill)
                    begin
                        tag_next[i]   = blk_reg;
                        valid_next[i] = 1'b1;
                        dirty_next[i] = 1'b0;
                    end
                    if (set_dirty)
                    begin
                        dirty_next[i] = 1'b1;
                    end
                end
                if (do_promote)
                begin
                    if (sel_reg[i])
                    begin
                        rank_next[i] = RANK_MAX;
                    end
                    else if (rank_reg[i] > sel_rank)
                    begin
                        rank_next[i] = rank_reg[i] - RANK_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            tag_reg[i] <= tag_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                count_reg[i] <= '0;
                rank_reg[i]  <= RANK_W'(i);
            end
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                count_reg[i] <= count_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= cmd.commit || (rsp_valid_reg && !rsp.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_status_reg   <= status_dec;
            rsp_entry_reg    <= grant_dec ? sel_idx_wide[INDEX_W-1:0] : '0;
            rsp_hit_reg      <= hit_dec;
            rsp_load_reg     <= load_dec;
            rsp_wb_reg       <= wb_dec;
            rsp_wb_block_reg <= wb_dec ? sel_tag_wide[BLOCK_NUM_W-1:0] : '0;
        end
    end

    assign sts.rsp_busy          = rsp_valid_reg && !rsp.ready;
    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = rsp_status_reg;
    assign rsp.granted_entry     = rsp_entry_reg;
    assign rsp.hit               = rsp_hit_reg;
    assign rsp.load_request      = rsp_load_reg;
    assign rsp.writeback_request = rsp_wb_reg;
    assign rsp.writeback_block   = rsp_wb_block_reg;

endmodule

// ===== rtl/core/lru_block_buffer_cache.sv =====
`timescale 1ns / 1ps

// Metadata controller of a block buffer cache with LRU replacement and per-entry
// reference counts. Each request word (acquire a block, mark an entry dirty, release
// an entry) yields exactly one response word carrying a status and, for an acquire,
// the granted entry, hit, load and writeback indications. A request passes through
// capture, parallel tag and free-entry search, hit/victim selection by a pairwise
// rank compare, and the state update that loads its response into the output
// register; the next request is accepted in the cycle after the update, so no new
// request is taken while one is still in flight.
// A response that is not taken holds the next request at the update step. All
// metadata sits in flip-flops and is ready right after reset.
module lru_block_buffer_cache
    import lbc_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int BLOCK_BITS = 32,
    parameter int COUNT_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    lbc_req_if.sink   req,
    lbc_rsp_if.source rsp
);

    lbc_cmd_t cmd;
    lbc_sts_t sts;

    lbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lbc_datapath #(
        .ENTRIES    (ENTRIES),
        .BLOCK_BITS (BLOCK_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (req.operation),
        .block_number (req.block_number),
        .entry_index  (req.entry_index),
        .rsp          (rsp)
    );

endmodule
